[rtl/core/cwd_pkg.sv]
// cwd_pkg: shared types, width codes and the non-spacing interval table
// for the display width pipeline. No dependencies.

package cwd_pkg;

    localparam int CP_W          = 21;
    localparam int NS_TABLE_LEN  = 142;
    localparam int CWD_COMBINING_INTERVALS = 142;
    localparam int MATCH_GROUP   = 16;

    typedef logic [CP_W-1:0]   t_cp;
    typedef logic signed [2:0] t_width;

    localparam t_width W_CTRL   = 3'sb111;
    localparam t_width W_ZERO   = 3'sb000;
    localparam t_width W_NARROW = 3'sb001;
    localparam t_width W_WIDE   = 3'sb010;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } t_span;

    // sorted non-spacing (combining) intervals, inclusive bounds
    localparam t_span NS_TABLE [NS_TABLE_LEN] = '{
        '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00486}, '{21'h00488, 21'h00489},
        '{21'h00591, 21'h005BD}, '{21'h005BF, 21'h005BF}, '{21'h005C1, 21'h005C2},
        '{21'h005C4, 21'h005C5}, '{21'h005C7, 21'h005C7}, '{21'h00600, 21'h00603},
        '{21'h00610, 21'h00615}, '{21'h0064B, 21'h0065E}, '{21'h00670, 21'h00670},
        '{21'h006D6, 21'h006E4}, '{21'h006E7, 21'h006E8}, '{21'h006EA, 21'h006ED},
        '{21'h0070F, 21'h0070F}, '{21'h00711, 21'h00711}, '{21'h00730, 21'h0074A},
        '{21'h007A6, 21'h007B0}, '{21'h007EB, 21'h007F3}, '{21'h00901, 21'h00902},
        '{21'h0093C, 21'h0093C}, '{21'h00941, 21'h00948}, '{21'h0094D, 21'h0094D},
        '{21'h00951, 21'h00954}, '{21'h00962, 21'h00963}, '{21'h00981, 21'h00981},
        '{21'h009BC, 21'h009BC}, '{21'h009C1, 21'h009C4}, '{21'h009CD, 21'h009CD},
        '{21'h009E2, 21'h009E3}, '{21'h00A01, 21'h00A02}, '{21'h00A3C, 21'h00A3C},
        '{21'h00A41, 21'h00A42}, '{21'h00A47, 21'h00A48}, '{21'h00A4B, 21'h00A4D},
        '{21'h00A70, 21'h00A71}, '{21'h00A81, 21'h00A82}, '{21'h00ABC, 21'h00ABC},
        '{21'h00AC1, 21'h00AC5}, '{21'h00AC7, 21'h00AC8}, '{21'h00ACD, 21'h00ACD},
        '{21'h00AE2, 21'h00AE3}, '{21'h00B01, 21'h00B01}, '{21'h00B3C, 21'h00B3C},
        '{21'h00B3F, 21'h00B3F}, '{21'h00B41, 21'h00B43}, '{21'h00B4D, 21'h00B4D},
        '{21'h00B56, 21'h00B56}, '{21'h00B82, 21'h00B82}, '{21'h00BC0, 21'h00BC0},
        '{21'h00BCD, 21'h00BCD}, '{21'h00C3E, 21'h00C40}, '{21'h00C46, 21'h00C48},
        '{21'h00C4A, 21'h00C4D}, '{21'h00C55, 21'h00C56}, '{21'h00CBC, 21'h00CBC},
        '{21'h00CBF, 21'h00CBF}, '{21'h00CC6, 21'h00CC6}, '{21'h00CCC, 21'h00CCD},
        '{21'h00CE2, 21'h00CE3}, '{21'h00D41, 21'h00D43}, '{21'h00D4D, 21'h00D4D},
        '{21'h00DCA, 21'h00DCA}, '{21'h00DD2, 21'h00DD4}, '{21'h00DD6, 21'h00DD6},
        '{21'h00E31, 21'h00E31}, '{21'h00E34, 21'h00E3A}, '{21'h00E47, 21'h00E4E},
        '{21'h00EB1, 21'h00EB1}, '{21'h00EB4, 21'h00EB9}, '{21'h00EBB, 21'h00EBC},
        '{21'h00EC8, 21'h00ECD}, '{21'h00F18, 21'h00F19}, '{21'h00F35, 21'h00F35},
        '{21'h00F37, 21'h00F37}, '{21'h00F39, 21'h00F39}, '{21'h00F71, 21'h00F7E},
        '{21'h00F80, 21'h00F84}, '{21'h00F86, 21'h00F87}, '{21'h00F90, 21'h00F97},
        '{21'h00F99, 21'h00FBC}, '{21'h00FC6, 21'h00FC6}, '{21'h0102D, 21'h01030},
        '{21'h01032, 21'h01032}, '{21'h01036, 21'h01037}, '{21'h01039, 21'h01039},
        '{21'h01058, 21'h01059}, '{21'h01160, 21'h011FF}, '{21'h0135F, 21'h0135F},
        '{21'h01712, 21'h01714}, '{21'h01732, 21'h01734}, '{21'h01752, 21'h01753},
        '{21'h01772, 21'h01773}, '{21'h017B4, 21'h017B5}, '{21'h017B7, 21'h017BD},
        '{21'h017C6, 21'h017C6}, '{21'h017C9, 21'h017D3}, '{21'h017DD, 21'h017DD},
        '{21'h0180B, 21'h0180D}, '{21'h018A9, 21'h018A9}, '{21'h01920, 21'h01922},
        '{21'h01927, 21'h01928}, '{21'h01932, 21'h01932}, '{21'h01939, 21'h0193B},
        '{21'h01A17, 21'h01A18}, '{21'h01B00, 21'h01B03}, '{21'h01B34, 21'h01B34},
        '{21'h01B36, 21'h01B3A}, '{21'h01B3C, 21'h01B3C}, '{21'h01B42, 21'h01B42},
        '{21'h01B6B, 21'h01B73}, '{21'h01DC0, 21'h01DCA}, '{21'h01DFE, 21'h01DFF},
        '{21'h0200B, 21'h0200F}, '{21'h0202A, 21'h0202E}, '{21'h02060, 21'h02063},
        '{21'h0206A, 21'h0206F}, '{21'h020D0, 21'h020EF}, '{21'h0302A, 21'h0302F},
        '{21'h03099, 21'h0309A}, '{21'h0A806, 21'h0A806}, '{21'h0A80B, 21'h0A80B},
        '{21'h0A825, 21'h0A826}, '{21'h0FB1E, 21'h0FB1E}, '{21'h0FE00, 21'h0FE0F},
        '{21'h0FE20, 21'h0FE23}, '{21'h0FEFF, 21'h0FEFF}, '{21'h0FFF9, 21'h0FFFB},
        '{21'h10A01, 21'h10A03}, '{21'h10A05, 21'h10A06}, '{21'h10A0C, 21'h10A0F},
        '{21'h10A38, 21'h10A3A}, '{21'h10A3F, 21'h10A3F}, '{21'h1D167, 21'h1D169},
        '{21'h1D173, 21'h1D182}, '{21'h1D185, 21'h1D18B}, '{21'h1D1AA, 21'h1D1AD},
        '{21'h1D242, 21'h1D244}, '{21'h0E0001 & 21'h1FFFFF, 21'h0E0001 & 21'h1FFFFF},
        '{21'h0E0020 & 21'h1FFFFF, 21'h0E007F & 21'h1FFFFF},
        '{21'h0E0100 & 21'h1FFFFF, 21'h0E01EF & 21'h1FFFFF}
    };

endpackage

[rtl/core/cwd_match.sv]
// cwd_match: two-stage non-spacing interval matcher.
// Depends on cwd_pkg for the interval table and group size.

module cwd_match #(
    parameter int COMBINING_INTERVALS = cwd_pkg::CWD_COMBINING_INTERVALS,
    localparam int N_USED = (COMBINING_INTERVALS < cwd_pkg::NS_TABLE_LEN) ?
                            COMBINING_INTERVALS : cwd_pkg::NS_TABLE_LEN,
    localparam int N_GROUPS = (N_USED + cwd_pkg::MATCH_GROUP - 1) / cwd_pkg::MATCH_GROUP
) (
    input  logic                 i_clk,
    input  cwd_pkg::t_cp         i_code_point,
    output logic [N_GROUPS-1:0]  o_group_hit
);
    import cwd_pkg::*;

    logic [N_USED-1:0]   n_hit;
    logic [N_USED-1:0]   r_hit;
    logic [N_GROUPS-1:0] n_group_hit;
    logic [N_GROUPS-1:0] r_group_hit;

    // stage a: one range compare per interval
    always_comb begin
        for (int i = 0; i < N_USED; i++) begin
            n_hit[i] = (i_code_point >= NS_TABLE[i].lo) && (i_code_point <= NS_TABLE[i].hi);
        end
    end

    // stage b: or-reduce each group of hits
    always_comb begin
        for (int g = 0; g < N_GROUPS; g++) begin
            n_group_hit[g] = 1'b0;
            for (int k = 0; k < MATCH_GROUP; k++) begin
                if (g * MATCH_GROUP + k < N_USED) begin
                    n_group_hit[g] = n_group_hit[g] | r_hit[g * MATCH_GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit       <= n_hit;
        r_group_hit <= n_group_hit;
    end

    assign o_group_hit = r_group_hit;

endmodule

[rtl/core/char_display_width_top.sv]
// char_display_width_top: terminal column width of one code point per cycle while busy is low.
// Depends on cwd_pkg and cwd_match.

// One code point is taken on every clock cycle in which start is high and busy is
// low; its width comes out on o_column_width, marked by a one-cycle o_strobe, in
// request order. Width is -1 for controls, 0 for nul and combining marks, 1 for
// normal and 2 for East Asian wide characters. Each request passes registered
// steps in order: parallel range compares against the combining table, group
// reduction, and a merge of the class flags into the result. The sustained rate
// is one request per cycle while busy is low. The receiver cannot stall, so
// nothing is held back: busy is high only while reset is held and in the first
// cycle after it is released.

module char_display_width_top #(
    parameter int COMBINING_INTERVALS = cwd_pkg::CWD_COMBINING_INTERVALS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cwd_pkg::t_cp     i_code_point,
    output logic             o_strobe,
    output cwd_pkg::t_width  o_column_width
);
    import cwd_pkg::*;

    localparam int N_USED   = (COMBINING_INTERVALS < NS_TABLE_LEN) ?
                              COMBINING_INTERVALS : NS_TABLE_LEN;
    localparam int N_GROUPS = (N_USED + MATCH_GROUP - 1) / MATCH_GROUP;

    // class flags that ride alongside the interval matcher
    typedef struct packed {
        logic nul;
        logic ctrl;
        logic wide;
    } t_class;

    logic                r_ready;
    logic                accept;
    t_class              n_cls1;
    t_class              r_cls1;
    t_class              r_cls2;
    logic                r_v1;
    logic                r_v2;
    logic                r_strobe;
    t_width              n_width;
    t_width              r_width;
    logic [N_GROUPS-1:0] group_hit;

    assign accept = start && !busy;
    assign busy   = !r_ready;

    // stage 1: nul, control and wide classification, in parallel with the interval compares
    always_comb begin
        n_cls1.nul  = (i_code_point == '0);
        n_cls1.ctrl = (i_code_point < 21'h00020) ||
                      ((i_code_point >= 21'h0007F) && (i_code_point <= 21'h0009F));
        n_cls1.wide = ((i_code_point >= 21'h01100) && (i_code_point <= 21'h0115F)) ||
                      (i_code_point == 21'h02329) || (i_code_point == 21'h0232A) ||
                      ((i_code_point >= 21'h02E80) && (i_code_point <= 21'h0A4CF) &&
                       (i_code_point != 21'h0303F)) ||
                      ((i_code_point >= 21'h0AC00) && (i_code_point <= 21'h0D7A3)) ||
                      ((i_code_point >= 21'h0F900) && (i_code_point <= 21'h0FAFF)) ||
                      ((i_code_point >= 21'h0FE10) && (i_code_point <= 21'h0FE19)) ||
                      ((i_code_point >= 21'h0FE30) && (i_code_point <= 21'h0FE6F)) ||
                      ((i_code_point >= 21'h0FF00) && (i_code_point <= 21'h0FF60)) ||
                      ((i_code_point >= 21'h0FFE0) && (i_code_point <= 21'h0FFE6)) ||
                      ((i_code_point >= 21'h20000) && (i_code_point <= 21'h2FFFD)) ||
                      ((i_code_point >= 21'h30000) && (i_code_point <= 21'h3FFFD));
    end

    // stages 1 and 2 of the combining-mark search
    cwd_match #(
        .COMBINING_INTERVALS (COMBINING_INTERVALS)
    ) u_match (
        .i_clk        (i_clk),
        .i_code_point (i_code_point),
        .o_group_hit  (group_hit)
    );

    // stage 3: priority merge, nul before control before combining before wide
    always_comb begin
        if (r_cls2.nul) begin
            n_width = W_ZERO;
        end else if (r_cls2.ctrl) begin
            n_width = W_CTRL;
        end else if (|group_hit) begin
            n_width = W_ZERO;
        end else if (r_cls2.wide) begin
            n_width = W_WIDE;
        end else begin
            n_width = W_NARROW;
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_ready  <= 1'b1;
            r_v1     <= accept;
            r_v2     <= r_v1;
            r_strobe <= r_v2;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cls1  <= n_cls1;
        r_cls2  <= r_cls1;
        r_width <= n_width;
    end

    assign o_strobe       = r_strobe;
    assign o_column_width = r_width;

    // every request gets a result strobe
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("request did not produce a result after three cycles");

    // no result strobe without a matching earlier request
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 3))
        else $error("result strobe without a matching request");

    // nul always measures zero columns
    a_nul_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(accept, 3) && ($past(i_code_point, 3) == '0))
        |-> (o_column_width == W_ZERO))
        else $error("nul did not give zero width");

    // supplementary ideographic plane is wide
    a_plane2_wide : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(accept, 3) && ($past(i_code_point, 3) >= 21'h20000) &&
         ($past(i_code_point, 3) <= 21'h2FFFD))
        |-> (o_column_width == W_WIDE))
        else $error("plane 2 ideograph not reported wide");

    // output code is one of the four width codes
    a_code_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_column_width == W_CTRL) || (o_column_width == W_ZERO) ||
                     (o_column_width == W_NARROW) || (o_column_width == W_WIDE))
        else $error("column width code out of range");

endmodule
